FILE: sv/dpts_pkg.sv
// ----------------------------------------------------------------------------
// dpts_pkg: shared types and constants
// Field widths, function codes, FSM states and the ranked-cell record.
// ----------------------------------------------------------------------------
`default_nettype none
package dpts_pkg;

  localparam int ENTRIES_DEF = 1024;
  localparam int DIM_DEF     = 256;
  localparam int MAX_K_DEF   = 16;

  localparam int VAL_W   = 16;
  localparam int ENT_W   = 10;
  localparam int ELEM_W  = 8;
  localparam int PACK_W  = 8;
  localparam int LEN_W   = 9;
  localparam int SCORE_W = 40;
  localparam int LIM_W   = 5;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 64;

  localparam logic [LIM_W-1:0] LIMIT_RST = 5'd16;

  // register index, taken from paddr[3]
  localparam logic REG_LIMIT  = 1'b0;
  localparam logic REG_THRESH = 1'b1;

  typedef enum logic [1:0] {
    FN_WRITE  = 2'd0,
    FN_COMMIT = 2'd1,
    FN_CLEAR  = 2'd2,
    FN_QUERY  = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLR_RD,
    ST_CLR_WR,
    ST_META,
    ST_CHECK,
    ST_DOT,
    ST_DRAIN,
    ST_INS,
    ST_FIN,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic              vld;
    logic [PACK_W-1:0] pack;
    logic [LEN_W-1:0]  len;
  } meta_t;

  typedef struct packed {
    logic                      vld;
    logic signed [SCORE_W-1:0] score;
    logic [ENT_W-1:0]          ent;
    logic [PACK_W-1:0]         pack;
  } cell_t;

  typedef struct packed {
    logic clr;
    logic ins;
    logic shift;
  } cell_ctl_t;

endpackage
`default_nettype wire

FILE: sv/dpts_ram.sv
// ----------------------------------------------------------------------------
// dpts_ram: generic single-write, single-read RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module dpts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

FILE: sv/dpts_mac.sv
// ----------------------------------------------------------------------------
// dpts_mac: dot product accumulator
// Registered multiply, then accumulate; result saturated to 40 bits.
// ----------------------------------------------------------------------------
`default_nettype none
module dpts_mac #(
  parameter int DIM = dpts_pkg::DIM_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 clr_i,
  input  wire logic                                 vld_i,
  input  wire logic signed [dpts_pkg::VAL_W-1:0]    a_i,
  input  wire logic signed [dpts_pkg::VAL_W-1:0]    b_i,
  output logic                                      busy_o,
  output logic signed [dpts_pkg::SCORE_W-1:0]       sum_o
);

  localparam int PW   = 2 * dpts_pkg::VAL_W;
  localparam int ACCW = PW + $clog2(DIM + 1) + 1;
  localparam logic signed [ACCW-1:0] SMAX =
    ACCW'({1'b0, {(dpts_pkg::SCORE_W-1){1'b1}}});
  localparam logic signed [ACCW-1:0] SMIN =
    -ACCW'({1'b0, {(dpts_pkg::SCORE_W-1){1'b1}}}) - ACCW'(1);

  logic signed [PW-1:0]   prod_q;
  logic                   pv_q;
  logic signed [ACCW-1:0] acc_q, acc_d;

  always_comb begin
    acc_d = acc_q;
    if (clr_i) begin
      acc_d = '0;
    end else if (pv_q) begin
      acc_d = acc_q + ACCW'(prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q  <= 1'b0;
      acc_q <= '0;
    end else begin
      pv_q  <= vld_i & ~clr_i;
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign busy_o = vld_i | pv_q;

  always_comb begin
    if (acc_q > SMAX) begin
      sum_o = dpts_pkg::SCORE_W'(SMAX);
    end else if (acc_q < SMIN) begin
      sum_o = dpts_pkg::SCORE_W'(SMIN);
    end else begin
      sum_o = dpts_pkg::SCORE_W'(acc_q);
    end
  end

endmodule
`default_nettype wire

FILE: sv/dpts_cell.sv
// ----------------------------------------------------------------------------
// dpts_cell: one slot of the ranked result chain
// Keeps one candidate; inserts, shifts down on insertion, shifts up on pop.
// ----------------------------------------------------------------------------
`default_nettype none
module dpts_cell (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire dpts_pkg::cell_ctl_t ctl_i,
  input  wire dpts_pkg::cell_t     cand_i,
  input  wire dpts_pkg::cell_t     prev_i,
  input  wire logic                prev_beat_i,
  input  wire dpts_pkg::cell_t     next_i,
  output dpts_pkg::cell_t          cur_o,
  output logic                     beat_o
);

  dpts_pkg::cell_t cell_q, cell_d;

  // strict compare: an equal score stays ahead (lower entry index)
  assign beat_o = ctl_i.ins & (~cell_q.vld | (cand_i.score > cell_q.score));

  always_comb begin
    cell_d = cell_q;
    if (ctl_i.clr) begin
      cell_d.vld = 1'b0;
    end else if (ctl_i.shift) begin
      cell_d = next_i;
    end else if (prev_beat_i) begin
      cell_d = prev_i;
    end else if (beat_o) begin
      cell_d = cand_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cur_o = cell_q;

endmodule
`default_nettype wire

FILE: sv/dot_product_topk_search.sv
// ----------------------------------------------------------------------------
// dot_product_topk_search: flat vector store with top-k dot product search
// Stores vectors, tags and lengths; ranks matching entries by exact score.
// ----------------------------------------------------------------------------
// Write, commit, and query-element beats are taken one per cycle while idle.
// A clear-pack beat sweeps the entry table, reading then writing each entry.
// The last query element starts a scan of all ENTRIES slots: a skipped slot
// passes META and CHECK, a slot that scores zero without a dot product
// (empty or length mismatch) also passes INS, and a scored slot also passes
// DOT and DRAIN, the single MAC unit reading one element per cycle from the
// vector memory. Survivors enter a chain of MAX_K ranked cells. Results then
// leave best first, one beat per cycle while the receiver is ready, from the
// head of the chain; an empty answer is one beat with hit low. After reset a
// clearing pass over every slot zeroes the entry table; no input is taken
// until it ends, config writes are always taken. Input is held off (ready
// low) from the last query element until its final result beat is taken.
// ----------------------------------------------------------------------------
`default_nettype none
module dot_product_topk_search #(
  parameter int ENTRIES = dpts_pkg::ENTRIES_DEF,
  parameter int DIM     = dpts_pkg::DIM_DEF,
  parameter int MAX_K   = dpts_pkg::MAX_K_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // config port
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [dpts_pkg::ADDR_W-1:0]         paddr,
  input  wire logic [dpts_pkg::DATA_W-1:0]         pwdata,
  output logic      [dpts_pkg::DATA_W-1:0]         prdata,
  output logic                                     pready,
  // input channel
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [1:0]                          func_i,
  input  wire logic [dpts_pkg::ENT_W-1:0]          entry_i,
  input  wire logic [dpts_pkg::ELEM_W-1:0]         elem_i,
  input  wire logic signed [dpts_pkg::VAL_W-1:0]   value_i,
  input  wire logic [dpts_pkg::PACK_W-1:0]         pack_i,
  input  wire logic [dpts_pkg::LEN_W-1:0]          length_i,
  input  wire logic                                last_i,
  // result channel
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [dpts_pkg::ENT_W-1:0]               hit_entry_o,
  output logic [dpts_pkg::PACK_W-1:0]              hit_pack_o,
  output logic signed [dpts_pkg::SCORE_W-1:0]      score_o,
  output logic                                     hit_o,
  output logic                                     final_res_o
);

  localparam int EW = $clog2(ENTRIES);
  localparam int DW = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int QW = $clog2(DIM + 2);
  localparam int KW = $clog2(MAX_K + 1);
  localparam int MW = $bits(dpts_pkg::meta_t);

  // ---------------- config registers ----------------
  logic [dpts_pkg::LIM_W-1:0]          limit_q;
  logic signed [dpts_pkg::SCORE_W-1:0] thresh_q;
  logic                                cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= dpts_pkg::LIMIT_RST;
      thresh_q <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3])
        dpts_pkg::REG_LIMIT:  limit_q  <= pwdata[dpts_pkg::LIM_W-1:0];
        dpts_pkg::REG_THRESH: thresh_q <= pwdata[dpts_pkg::SCORE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      dpts_pkg::REG_LIMIT:
        prdata = dpts_pkg::DATA_W'(limit_q);
      dpts_pkg::REG_THRESH:
        prdata = dpts_pkg::DATA_W'(unsigned'(thresh_q));
      default: prdata = '0;
    endcase
  end

  // ---------------- control state ----------------
  dpts_pkg::state_e state_q, state_d;
  logic [EW-1:0]              e_q, e_d;        // scan / sweep slot
  logic [QW-1:0]              i_q, i_d;        // element issue count
  logic [QW-1:0]              qcnt_q, qcnt_d;  // query length so far
  logic [QW-1:0]              qlen_q, qlen_d;  // length of the running query
  logic [dpts_pkg::PACK_W-1:0] pack_q, pack_d; // query or clear pack
  logic [dpts_pkg::LEN_W-1:0] len_q, len_d;    // length of slot being scored
  logic [dpts_pkg::PACK_W-1:0] epack_q, epack_d;
  logic [KW-1:0]              ncnt_q, ncnt_d;  // kept candidates, saturating
  logic [KW-1:0]              rem_q, rem_d;    // result beats left
  logic                       empty_q, empty_d;
  logic signed [dpts_pkg::SCORE_W-1:0] cand_q, cand_d;
  logic                       rdv_q;           // RAM read data valid for MAC

  // memories
  logic                    st_we;
  logic [EW+DW-1:0]        st_waddr, st_raddr;
  logic [dpts_pkg::VAL_W-1:0] st_rdata, qb_rdata;
  logic                    qb_we;
  logic [DW-1:0]           qb_waddr, qb_raddr;
  logic                    mt_we;
  logic [EW-1:0]           mt_waddr, mt_raddr;
  dpts_pkg::meta_t         mt_wdata, mt_rdata;
  logic [MW-1:0]           mt_rraw;

  // MAC
  logic                    mac_clr, issue, mac_busy;
  logic signed [dpts_pkg::SCORE_W-1:0] mac_sum;

  // cells
  dpts_pkg::cell_ctl_t     ctl;
  dpts_pkg::cell_t         cand;
  dpts_pkg::cell_t         cells [MAX_K];
  logic                    beats [MAX_K];

  logic                    acc_in, last_slot, pack_ok, len_ok, keep;
  logic [KW-1:0]           lim_eff;

  assign acc_in    = in_valid_i & in_ready_o;
  assign last_slot = (32'(e_q) == 32'(ENTRIES - 1));
  assign mt_rdata  = dpts_pkg::meta_t'(mt_rraw);
  assign pack_ok   = mt_rdata.vld & ((pack_q == '0) | (mt_rdata.pack == pack_q));
  assign len_ok    = (mt_rdata.len != '0) && (32'(mt_rdata.len) <= 32'(DIM))
                     && (32'(mt_rdata.len) == 32'(qlen_q));
  assign lim_eff   = (32'(limit_q) > 32'(MAX_K)) ? KW'(MAX_K) : KW'(limit_q);
  assign keep      = (cand_q >= thresh_q) && (limit_q != '0);

  assign st_raddr  = {e_q, i_q[DW-1:0]};
  assign qb_raddr  = i_q[DW-1:0];
  assign st_waddr  = {EW'(entry_i), DW'(elem_i)};
  assign qb_waddr  = qcnt_q[DW-1:0];

  assign cand.vld   = 1'b1;
  assign cand.score = cand_q;
  assign cand.ent   = dpts_pkg::ENT_W'(e_q);
  assign cand.pack  = epack_q;

  always_comb begin
    state_d  = state_q;
    e_d      = e_q;
    i_d      = i_q;
    qcnt_d   = qcnt_q;
    qlen_d   = qlen_q;
    pack_d   = pack_q;
    len_d    = len_q;
    epack_d  = epack_q;
    ncnt_d   = ncnt_q;
    rem_d    = rem_q;
    empty_d  = empty_q;
    cand_d   = cand_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    st_we    = 1'b0;
    qb_we    = 1'b0;
    mt_we    = 1'b0;
    mt_waddr = e_q;
    mt_wdata = '0;
    mt_raddr = e_q;
    mac_clr  = 1'b0;
    issue    = 1'b0;
    ctl      = '0;

    unique case (state_q)
      dpts_pkg::ST_INIT: begin
        mt_we = 1'b1;
        e_d   = e_q + EW'(1);
        if (last_slot) begin
          state_d = dpts_pkg::ST_IDLE;
        end
      end

      dpts_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (acc_in) begin
          unique case (dpts_pkg::func_e'(func_i))
            dpts_pkg::FN_WRITE: begin
              st_we = (32'(entry_i) < 32'(ENTRIES)) && (32'(elem_i) < 32'(DIM));
            end
            dpts_pkg::FN_COMMIT: begin
              mt_we         = 32'(entry_i) < 32'(ENTRIES);
              mt_waddr      = EW'(entry_i);
              mt_wdata.vld  = 1'b1;
              mt_wdata.pack = pack_i;
              mt_wdata.len  = length_i;
            end
            dpts_pkg::FN_CLEAR: begin
              pack_d  = pack_i;
              e_d     = '0;
              state_d = dpts_pkg::ST_CLR_RD;
            end
            dpts_pkg::FN_QUERY: begin
              qb_we = 32'(qcnt_q) < 32'(DIM);
              if (32'(qcnt_q) <= 32'(DIM)) begin
                qcnt_d = qcnt_q + QW'(1);
              end
              if (last_i) begin
                qlen_d  = qcnt_d;
                qcnt_d  = '0;
                pack_d  = pack_i;
                e_d     = '0;
                ncnt_d  = '0;
                ctl.clr = 1'b1;
                state_d = dpts_pkg::ST_META;
              end
            end
            default: ;
          endcase
        end
      end

      dpts_pkg::ST_CLR_RD: begin
        state_d = dpts_pkg::ST_CLR_WR;
      end

      dpts_pkg::ST_CLR_WR: begin
        mt_wdata     = mt_rdata;
        mt_wdata.vld = 1'b0;
        mt_we        = mt_rdata.vld & (mt_rdata.pack == pack_q);
        e_d          = e_q + EW'(1);
        state_d      = last_slot ? dpts_pkg::ST_IDLE : dpts_pkg::ST_CLR_RD;
      end

      dpts_pkg::ST_META: begin
        state_d = dpts_pkg::ST_CHECK;
      end

      dpts_pkg::ST_CHECK: begin
        len_d   = mt_rdata.len;
        epack_d = mt_rdata.pack;
        i_d     = '0;
        mac_clr = 1'b1;
        if (!pack_ok) begin
          e_d     = e_q + EW'(1);
          state_d = last_slot ? dpts_pkg::ST_FIN : dpts_pkg::ST_META;
        end else if (!len_ok) begin
          cand_d  = '0;
          state_d = dpts_pkg::ST_INS;
        end else begin
          state_d = dpts_pkg::ST_DOT;
        end
      end

      dpts_pkg::ST_DOT: begin
        issue = 1'b1;
        i_d   = i_q + QW'(1);
        if (32'(i_q) + 32'd1 == 32'(len_q)) begin
          state_d = dpts_pkg::ST_DRAIN;
        end
      end

      dpts_pkg::ST_DRAIN: begin
        if (!mac_busy) begin
          cand_d  = mac_sum;
          state_d = dpts_pkg::ST_INS;
        end
      end

      dpts_pkg::ST_INS: begin
        ctl.ins = keep;
        if (keep && (32'(ncnt_q) < 32'(MAX_K))) begin
          ncnt_d = ncnt_q + KW'(1);
        end
        e_d     = e_q + EW'(1);
        state_d = last_slot ? dpts_pkg::ST_FIN : dpts_pkg::ST_META;
      end

      dpts_pkg::ST_FIN: begin
        rem_d   = (ncnt_q < lim_eff) ? ncnt_q : lim_eff;
        empty_d = (rem_d == '0);
        state_d = dpts_pkg::ST_OUT;
      end

      dpts_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          ctl.shift = 1'b1;
          rem_d     = rem_q - KW'(1);
          if (empty_q || (rem_q == KW'(1))) begin
            state_d = dpts_pkg::ST_IDLE;
          end
        end
      end

      default: state_d = dpts_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dpts_pkg::ST_INIT;
      e_q     <= '0;
      i_q     <= '0;
      qcnt_q  <= '0;
      qlen_q  <= '0;
      pack_q  <= '0;
      ncnt_q  <= '0;
      rem_q   <= '0;
      empty_q <= 1'b0;
      rdv_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      e_q     <= e_d;
      i_q     <= i_d;
      qcnt_q  <= qcnt_d;
      qlen_q  <= qlen_d;
      pack_q  <= pack_d;
      ncnt_q  <= ncnt_d;
      rem_q   <= rem_d;
      empty_q <= empty_d;
      rdv_q   <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q   <= len_d;
    epack_q <= epack_d;
    cand_q  <= cand_d;
  end

  // ---------------- storage ----------------
  dpts_ram #(.WIDTH(dpts_pkg::VAL_W), .DEPTH(ENTRIES * (2 ** DW))) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (value_i),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  dpts_ram #(.WIDTH(dpts_pkg::VAL_W), .DEPTH(DIM)) u_query (
    .clk_i   (clk_i),
    .we_i    (qb_we),
    .waddr_i (qb_waddr),
    .wdata_i (value_i),
    .raddr_i (qb_raddr),
    .rdata_o (qb_rdata)
  );

  dpts_ram #(.WIDTH(MW), .DEPTH(ENTRIES)) u_meta (
    .clk_i   (clk_i),
    .we_i    (mt_we),
    .waddr_i (mt_waddr),
    .wdata_i (mt_wdata),
    .raddr_i (mt_raddr),
    .rdata_o (mt_rraw)
  );

  dpts_mac #(.DIM(DIM)) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clr_i  (mac_clr),
    .vld_i  (rdv_q),
    .a_i    (signed'(st_rdata)),
    .b_i    (signed'(qb_rdata)),
    .busy_o (mac_busy),
    .sum_o  (mac_sum)
  );

  // ---------------- ranked cell chain ----------------
  for (genvar k = 0; k < MAX_K; k++) begin : g_cell
    dpts_pkg::cell_t prev, next;
    logic            prev_beat;
    if (k == 0) begin : g_head
      assign prev      = '0;
      assign prev_beat = 1'b0;
    end else begin : g_body
      assign prev      = cells[k-1];
      assign prev_beat = beats[k-1];
    end
    if (k == MAX_K - 1) begin : g_tail
      assign next = '0;
    end else begin : g_mid
      assign next = cells[k+1];
    end
    dpts_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .cand_i      (cand),
      .prev_i      (prev),
      .prev_beat_i (prev_beat),
      .next_i      (next),
      .cur_o       (cells[k]),
      .beat_o      (beats[k])
    );
  end

  // result beat comes straight off the head cell
  assign hit_o       = ~empty_q;
  assign hit_entry_o = empty_q ? '0 : cells[0].ent;
  assign hit_pack_o  = empty_q ? '0 : cells[0].pack;
  assign score_o     = empty_q ? '0 : cells[0].score;
  assign final_res_o = empty_q | (rem_q == KW'(1));

endmodule
`default_nettype wire

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for dot_product_topk_search
// Self-checking testbench. An initial block queues input beats and sets the
// registers between phases. A clocked driver sends the beats and a clocked
// monitor takes the results. A scoring model predicts the ranked hits for
// each search, and each result beat is checked against them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;

  localparam int NENT    = 1024;
  localparam int NDIM    = 256;
  localparam int TOPK    = 16;
  localparam int LIMIT   = 3000000;
  localparam int SETTLE  = 2300;   // covers a clear sweep (a read and a write per entry)

  localparam int VAL_W   = dpts_pkg::VAL_W;
  localparam int ENT_W   = dpts_pkg::ENT_W;
  localparam int ELEM_W  = dpts_pkg::ELEM_W;
  localparam int PACK_W  = dpts_pkg::PACK_W;
  localparam int LEN_W   = dpts_pkg::LEN_W;
  localparam int SCORE_W = dpts_pkg::SCORE_W;
  localparam int LIM_W   = dpts_pkg::LIM_W;
  localparam int ADDR_W  = dpts_pkg::ADDR_W;
  localparam int DATA_W  = dpts_pkg::DATA_W;

  typedef struct {
    dpts_pkg::func_e          func;
    logic [ENT_W-1:0]         ent;
    logic [ELEM_W-1:0]        elem;
    logic signed [VAL_W-1:0]  val;
    logic [PACK_W-1:0]        pack;
    logic [LEN_W-1:0]         len;
    logic                     is_last;
  } beat_t;

  typedef struct {
    logic [ENT_W-1:0]          ent;
    logic [PACK_W-1:0]         pack;
    logic signed [SCORE_W-1:0] score;
    logic                      hit;
    logic                      fin;
  } hit_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                     psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0]        paddr = '0;
  logic [DATA_W-1:0]        pwdata = '0;
  logic [DATA_W-1:0]        prdata;
  logic                     pready;

  logic                     in_valid = 1'b0;
  logic                     in_ready_o;
  logic [1:0]               func_d = '0;
  logic [ENT_W-1:0]         entry_d = '0;
  logic [ELEM_W-1:0]        elem_d = '0;
  logic signed [VAL_W-1:0]  value_d = '0;
  logic [PACK_W-1:0]        pack_d = '0;
  logic [LEN_W-1:0]         length_d = '0;
  logic                     last_d = 1'b0;

  logic                     out_valid_o;
  logic                     out_ready = 1'b0;
  logic [ENT_W-1:0]         hit_entry_o;
  logic [PACK_W-1:0]        hit_pack_o;
  logic signed [SCORE_W-1:0] score_o;
  logic                     hit_o;
  logic                     final_res_o;

  dot_product_topk_search DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid_i(in_valid), .in_ready_o(in_ready_o),
    .func_i(func_d), .entry_i(entry_d), .elem_i(elem_d), .value_i(value_d),
    .pack_i(pack_d), .length_i(length_d), .last_i(last_d),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready),
    .hit_entry_o(hit_entry_o), .hit_pack_o(hit_pack_o), .score_o(score_o),
    .hit_o(hit_o), .final_res_o(final_res_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Scoring model: mirror of the store, query buffer and registers
  // --------------------------------------------------------------------------
  shortint          vec_mem [NENT*NDIM];
  bit               slot_vld [NENT];
  logic [LEN_W-1:0] slot_len [NENT];
  logic [PACK_W-1:0] slot_pack [NENT];
  shortint          qry_buf [NDIM];
  int               qry_cnt = 0;
  int               lim_reg = 16;
  longint           thr_reg = 0;

  hit_t   hits_due[$];   // ranked hits still to arrive
  beat_t  send_q[$];     // beats waiting for the driver
  int     errors = 0;

  function automatic longint dot_score(int e);
    longint acc;
    int n;
    acc = 0;
    n = slot_len[e];
    if (n == 0 || n > NDIM || n != qry_cnt) return 0;
    for (int i = 0; i < n; i++)
      acc += longint'(int'(vec_mem[e*NDIM+i]) * int'(qry_buf[i]));
    if (acc > 64'sd549755813887) acc = 64'sd549755813887;
    if (acc < -64'sd549755813888) acc = -64'sd549755813888;
    return acc;
  endfunction

  task automatic rank_matches(logic [PACK_W-1:0] qpack);
    longint bs [TOPK];
    int     be [TOPK];
    int     lim, n, p;
    longint s;
    hit_t   h;
    lim = (lim_reg > TOPK) ? TOPK : lim_reg;
    n = 0;
    for (int e = 0; e < NENT; e++) begin
      if (!slot_vld[e]) continue;
      if (qpack != 0 && slot_pack[e] != qpack) continue;
      s = dot_score(e);
      if (s < thr_reg || lim == 0) continue;
      if (n < lim) begin
        p = n;
        n++;
      end else if (s > bs[lim-1]) begin
        p = lim - 1;
      end else begin
        continue;
      end
      while (p > 0 && bs[p-1] < s) begin
        bs[p] = bs[p-1];
        be[p] = be[p-1];
        p--;
      end
      bs[p] = s;
      be[p] = e;
    end
    if (n == 0) begin
      h = '{ent: '0, pack: '0, score: '0, hit: 1'b0, fin: 1'b1};
      hits_due = {hits_due, h};
    end
    for (int k = 0; k < n; k++) begin
      h.ent   = ENT_W'(be[k]);
      h.pack  = slot_pack[be[k]];
      h.score = bs[k][SCORE_W-1:0];
      h.hit   = 1'b1;
      h.fin   = (k + 1 == n);
      hits_due = {hits_due, h};
    end
  endtask

  task automatic apply_beat(beat_t b);
    case (b.func)
      dpts_pkg::FN_WRITE: vec_mem[b.ent*NDIM+b.elem] = b.val;
      dpts_pkg::FN_COMMIT: begin
        slot_vld[b.ent]  = 1'b1;
        slot_pack[b.ent] = b.pack;
        slot_len[b.ent]  = b.len;
      end
      dpts_pkg::FN_CLEAR: begin
        for (int e = 0; e < NENT; e++)
          if (slot_vld[e] && slot_pack[e] == b.pack) slot_vld[e] = 1'b0;
      end
      default: begin
        if (qry_cnt < NDIM) qry_buf[qry_cnt] = b.val;
        if (qry_cnt <= NDIM) qry_cnt++;
        if (b.is_last) begin
          rank_matches(b.pack);
          qry_cnt = 0;
        end
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Driver: input beats change on the falling edge
  // --------------------------------------------------------------------------
  beat_t cur_beat;
  logic  in_fire = 1'b0;
  int    tx_gap = 0;
  bit    tx_idle_on = 1'b1;

  always @(negedge clk_i) begin
    if (!in_valid || in_fire) begin
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (send_q.size() > 0) begin
        cur_beat = send_q.pop_front();
        func_d   <= cur_beat.func;
        entry_d  <= cur_beat.ent;
        elem_d   <= cur_beat.elem;
        value_d  <= cur_beat.val;
        pack_d   <= cur_beat.pack;
        length_d <= cur_beat.len;
        last_d   <= cur_beat.is_last;
        in_valid <= 1'b1;
        tx_gap = tx_idle_on ? $urandom_range(0, 9) : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // accepted beat goes into the model at the edge that takes it
  always @(posedge clk_i) begin
    in_fire <= in_valid && in_ready_o;
    if (in_valid && in_ready_o) apply_beat(cur_beat);
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls per beat, one long hold-off to back up the block
  // --------------------------------------------------------------------------
  logic out_fire = 1'b0;
  int   rx_wait = 0;
  int   rx_hold = 0;
  bit   hold_done = 1'b0;
  bit   rx_idle_on = 1'b1;
  int   beats_seen = 0;

  always @(negedge clk_i) begin
    if (out_fire) begin
      rx_wait = rx_idle_on ? $urandom_range(0, 9) : 0;
      if (!hold_done && beats_seen >= 30) begin
        rx_hold = 500;
        hold_done = 1'b1;
      end
    end
    if (rx_hold > 0) begin
      rx_hold--;
      out_ready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: compare each result beat against the oldest predicted hit
  always @(posedge clk_i) begin
    hit_t h;
    out_fire <= out_valid_o && out_ready;
    if (out_valid_o && out_ready) begin
      beats_seen++;
      if (hits_due.size() == 0) begin
        $display("%0t: unexpected result beat entry %0d score %0d", $time,
                 hit_entry_o, score_o);
        errors++;
      end else begin
        h = hits_due.pop_front();
        if (hit_entry_o !== h.ent) begin
          $display("%0t: hit_entry exp %0d got %0d", $time, h.ent, hit_entry_o);
          errors++;
        end
        if (hit_pack_o !== h.pack) begin
          $display("%0t: hit_pack exp %0d got %0d", $time, h.pack, hit_pack_o);
          errors++;
        end
        if (score_o !== h.score) begin
          $display("%0t: score exp %0d got %0d", $time, h.score, score_o);
          errors++;
        end
        if (hit_o !== h.hit) begin
          $display("%0t: hit exp %0b got %0b", $time, h.hit, hit_o);
          errors++;
        end
        if (final_res_o !== h.fin) begin
          $display("%0t: final_res exp %0b got %0b", $time, h.fin, final_res_o);
          errors++;
        end
      end
    end
  end

  int cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  bit [NDIM-1:0] gen_wr [NENT];   // elements queued for writing, per slot
  int n_beats = 0;

  task automatic queue_beat(dpts_pkg::func_e f, int e, int el, int v, int p, int ln,
                            bit lst);
    beat_t b;
    b.func = f; b.ent = ENT_W'(e); b.elem = ELEM_W'(el); b.val = VAL_W'(v);
    b.pack = PACK_W'(p); b.len = LEN_W'(ln); b.is_last = lst;
    if (f == dpts_pkg::FN_WRITE) gen_wr[e][el] = 1'b1;
    send_q = {send_q, b};
    n_beats++;
  endtask

  // a commit may only name a length whose elements were all written
  task automatic queue_commit(int e, int p, int ln);
    int l;
    l = ln;
    if (l >= 1 && l <= NDIM)
      for (int i = 0; i < l; i++)
        if (!gen_wr[e][i]) begin
          l = $urandom_range(0, 1) ? 0 : $urandom_range(NDIM+1, 511);
          break;
        end
    queue_beat(dpts_pkg::FN_COMMIT, e, $urandom_range(0, 255), $urandom_range(0, 65535),
               p, l, 1'b0);
  endtask

  function automatic int pick_val();
    case ($urandom_range(0, 9))
      0: return -32768;
      1: return 32767;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic int pick_pack();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 255;
      2: return $urandom_range(0, 255);
      default: return $urandom_range(1, 3);
    endcase
  endfunction

  function automatic int pick_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
  endfunction

  task automatic queue_query(int ln, int p);
    for (int i = 0; i < ln; i++)
      queue_beat(dpts_pkg::FN_QUERY, $urandom_range(0, 1023), $urandom_range(0, 255),
                 pick_val(), p, $urandom_range(0, 511), i == ln - 1);
  endtask

  // sender holds off until every result is in and any clear sweep is over
  task automatic wait_quiet();
    while (send_q.size() != 0 || in_valid || hits_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_reg(logic idx, logic [DATA_W-1:0] data);
    logic [DATA_W-1:0] rd_exp;
    if (idx == dpts_pkg::REG_LIMIT) rd_exp = DATA_W'(data[LIM_W-1:0]);
    else rd_exp = DATA_W'(data[SCORE_W-1:0]);
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 3'b000}; pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    if (prdata !== rd_exp || pready !== 1'b1) begin
      $display("%0t: register %0d read exp %0h got %0h", $time, idx, rd_exp, prdata);
      errors++;
    end
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == dpts_pkg::REG_LIMIT) lim_reg = int'(data[LIM_W-1:0]);
    else thr_reg = longint'(signed'(data[SCORE_W-1:0]));
  endtask

  int     ph_lim [7] = '{16, 0, 31, 1, 3, 16, 7};
  longint ph_thr [7] = '{0, 0, -64'sd549755813888, 64'sd549755813887,
                         64'sd268435456, -64'sd1073741824, 0};

  initial begin
    int goal, e, ln, r;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes, replace, empty, over-long, clears, no match
    queue_beat(dpts_pkg::FN_WRITE, 0, 0, 32767, 0, 0, 0);
    queue_beat(dpts_pkg::FN_WRITE, 0, 1, -32768, 0, 0, 0);
    queue_commit(0, 1, 2);
    queue_beat(dpts_pkg::FN_WRITE, 1023, 0, -32768, 255, 511, 1);
    queue_beat(dpts_pkg::FN_WRITE, 1023, 1, -32768, 255, 511, 1);
    queue_commit(1023, 255, 2);
    queue_commit(5, 0, 0);           // empty entry
    queue_commit(6, 2, 511);         // length beyond the vector size
    queue_beat(dpts_pkg::FN_WRITE, 2, 255, 16'h5555, 0, 0, 0);
    queue_query(2, 0);               // all packs
    queue_query(1, 255);             // length mismatch
    queue_commit(0, 1, 1);           // replace a valid slot
    queue_query(1, 1);
    queue_beat(dpts_pkg::FN_CLEAR, 0, 0, 0, 0, 0, 0);
    queue_beat(dpts_pkg::FN_CLEAR, 0, 0, 0, 7, 0, 0);
    queue_query(2, 0);
    queue_query(1, 9);               // nothing matches: empty answer

    // over-long query: every entry scores zero
    queue_query(NDIM + 2, 0);
    wait_quiet();

    for (int ph = 0; ph < 7; ph++) begin
      set_reg(dpts_pkg::REG_LIMIT, DATA_W'(ph_lim[ph]));
      set_reg(dpts_pkg::REG_THRESH, ph_thr[ph]);
      tx_idle_on = ph != 2;
      rx_idle_on = ph != 4;
      goal = n_beats + 22;
      while (n_beats < goal) begin
        r = $urandom_range(0, 99);
        e = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 15);
        if (r < 45) begin
          ln = pick_len();
          for (int i = 0; i < ln; i++)
            queue_beat(dpts_pkg::FN_WRITE, e, i, pick_val(), 0, 0, 0);
          queue_commit(e, pick_pack(), ln);
        end else if (r < 80) begin
          queue_query(pick_len(), pick_pack());
        end else if (r < 90) begin
          queue_beat(dpts_pkg::FN_WRITE, e, $urandom_range(0, 255), pick_val(),
                     $urandom_range(0, 255), $urandom_range(0, 511), $urandom_range(0, 1));
        end else if (r < 95) begin
          queue_commit(e, pick_pack(), $urandom_range(0, 511));
        end else if (r < 97) begin
          queue_beat(dpts_pkg::FN_CLEAR, $urandom_range(0, 1023), 0, 0, pick_pack(), 0, 0);
        end else begin
          queue_query(1, $urandom_range(0, 255));
        end
      end
      wait_quiet();
    end

    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
